// File: hw/rtl/alignment_column_profile_counter_core_defines.svh
// Assertion macros shared by the profile counter modules.
`ifndef ALIGNMENT_COLUMN_PROFILE_COUNTER_CORE_DEFINES_SVH
`define ALIGNMENT_COLUMN_PROFILE_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/acpc_pkg.sv
// Shared constants, command/status types and helpers for the profile counter.
package acpc_pkg;

  // Sizes
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_SEQ         = 4096;
  localparam int ALPHABET_SIZE   = 20;
  localparam int TRAN_BINS       = 4;

  // Field widths
  localparam int CNT_W    = 13;
  localparam int FUNC_W   = 2;
  localparam int CODE_W   = 5;
  localparam int LABEL_W  = 12;
  localparam int RCOL_W   = 10;
  localparam int RBIN_W   = 5;
  localparam int CCOUNT_W = 11;

  // Stream data layout
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CODE_LSB   = 0;
  localparam int LABEL_LSB  = CODE_LSB + CODE_W;
  localparam int RCOL_LSB   = LABEL_LSB + LABEL_W;
  localparam int RBIN_LSB   = RCOL_LSB + RCOL_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * CNT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLUSTER = 1'b1;
  localparam logic [CCOUNT_W-1:0]  COLUMN_COUNT_RST   = CCOUNT_W'(1024);

  // Item operation codes
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACCUM = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  localparam logic [CODE_W-1:0] GAP_CODE = CODE_W'(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SEQ);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic do_acc;
    logic load_out;
    logic clr_init;
    logic clr_step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              clr_last;
    logic              out_free;
  } dp_sts_t;

  // Saturating increment of one count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// File: hw/rtl/acpc_ctrl.sv
// Controller state machine: item acceptance, clearing sweep, accumulate and read steps.
`include "alignment_column_profile_counter_core_defines.svh"

module acpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  acpc_pkg::dp_sts_t sts,
  output acpc_pkg::dp_cmd_t cmd
);
  import acpc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ACC   = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tready && in_tvalid;

  // Decode next state and issue commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = accept;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (sts.func)
            FN_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            FN_ACCUM: state_nxt = ST_ACC;
            FN_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ACPC_ASSERT_NEXT(a_read_goes_to_read,
    (state_r == ST_IDLE) && in_tvalid && (sts.func == FN_READ),
    state_r == ST_READ, "read item did not enter read step")
  `ACPC_ASSERT_NEXT(a_clear_ends_idle,
    (state_r == ST_CLEAR) && sts.clr_last,
    state_r == ST_IDLE, "clearing sweep did not end")

endmodule

// File: hw/rtl/acpc_dp.sv
// Datapath: configuration registers, count memories, sequence state and output register.
`include "alignment_column_profile_counter_core_defines.svh"

module acpc_dp #(
  parameter int MAX_COLUMNS = acpc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [acpc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [acpc_pkg::FUNC_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [acpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  acpc_pkg::dp_cmd_t               cmd,
  output acpc_pkg::dp_sts_t               sts
);
  import acpc_pkg::*;

  localparam int CW         = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LW         = CW + 1;
  localparam int RES_ROW_W  = ALPHABET_SIZE * CNT_W;
  localparam int TRAN_ROW_W = TRAN_BINS * CNT_W;

  // Configuration
  logic [CCOUNT_W-1:0] col_cnt_r;
  logic [LABEL_W-1:0]  tgt_r;

  // Count memories, one row per column
  logic [RES_ROW_W-1:0]  res_mem  [MAX_COLUMNS];
  logic [TRAN_ROW_W-1:0] tran_mem [MAX_COLUMNS];
  logic [RES_ROW_W-1:0]  res_rd_r;
  logic [TRAN_ROW_W-1:0] tran_rd_r;

  // Latched item
  logic [CODE_W-1:0]  code_r;
  logic [LABEL_W-1:0] label_r;
  logic [RBIN_W-1:0]  rbin_r;
  logic [CW-1:0]      addr_r;
  logic               oob_r;

  // Sequence state
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             prev_gap_r;
  logic             member_r, member_nxt;
  logic [CNT_W-1:0] members_r;
  logic [CW-1:0]    clr_cnt_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Item fields
  logic [CODE_W-1:0]  in_code;
  logic [LABEL_W-1:0] in_label;
  logic [RCOL_W-1:0]  in_rcol;
  logic [RBIN_W-1:0]  in_rbin;
  logic [31:0]        rcol32;
  logic [31:0]        cc32;

  // Working values
  logic [LW-1:0]         len, col_ext, col_inc;
  logic [CW-1:0]         acc_col, rd_addr;
  logic                  gap, first_col, origin_gap;
  logic [1:0]            tbin;
  logic [RES_ROW_W-1:0]  res_wr;
  logic [TRAN_ROW_W-1:0] tran_wr;
  logic                  mem_we;
  logic [CW-1:0]         mem_wa;
  logic [RES_ROW_W-1:0]  res_wd;
  logic [TRAN_ROW_W-1:0] tran_wd;
  logic [CNT_W-1:0]      entry;

  assign in_code  = in_tdata[CODE_LSB +: CODE_W];
  assign in_label = in_tdata[LABEL_LSB +: LABEL_W];
  assign in_rcol  = in_tdata[RCOL_LSB +: RCOL_W];
  assign in_rbin  = in_tdata[RBIN_LSB +: RBIN_W];
  assign rcol32   = 32'(in_rcol);
  assign cc32     = 32'(col_cnt_r);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= COLUMN_COUNT_RST;
      tgt_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT:   col_cnt_r <= cfg_wdata[CCOUNT_W-1:0];
        REG_TARGET_CLUSTER: tgt_r     <= cfg_wdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sequence length and the current column
  always_comb begin
    if (cc32 == 32'd0) begin
      len = LW'(1);
    end else if (cc32 > 32'(MAX_COLUMNS)) begin
      len = LW'(MAX_COLUMNS);
    end else begin
      len = cc32[LW-1:0];
    end
    col_ext = ({1'b0, pos_r} >= len) ? len - LW'(1) : {1'b0, pos_r};
    acc_col = col_ext[CW-1:0];
    rd_addr = (in_tuser == FN_READ) ? rcol32[CW-1:0] : acc_col;
  end

  // Build the updated rows for one residue
  always_comb begin
    gap        = (code_r >= GAP_CODE);
    first_col  = (addr_r == '0);
    member_nxt = first_col ? (label_r == tgt_r) : member_r;
    origin_gap = !first_col && prev_gap_r;
    tbin       = {origin_gap, gap};
    col_inc    = {1'b0, addr_r} + LW'(1);
    pos_nxt    = (col_inc >= len) ? '0 : col_inc[CW-1:0];
    res_wr     = res_rd_r;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (!gap && (code_r == CODE_W'(i))) begin
        res_wr[i*CNT_W +: CNT_W] = sat_inc(res_rd_r[i*CNT_W +: CNT_W]);
      end
    end
    tran_wr = tran_rd_r;
    for (int j = 0; j < TRAN_BINS; j++) begin
      if (tbin == 2'(j)) begin
        tran_wr[j*CNT_W +: CNT_W] = sat_inc(tran_rd_r[j*CNT_W +: CNT_W]);
      end
    end
  end

  // Share one write port between accumulate and clearing sweep
  always_comb begin
    mem_we  = (cmd.do_acc && member_nxt) || cmd.clr_step;
    mem_wa  = cmd.clr_step ? clr_cnt_r : addr_r;
    res_wd  = cmd.clr_step ? '0 : res_wr;
    tran_wd = cmd.clr_step ? '0 : tran_wr;
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_mem[mem_wa]  <= res_wd;
      tran_mem[mem_wa] <= tran_wd;
    end
    if (cmd.accept) begin
      res_rd_r  <= res_mem[rd_addr];
      tran_rd_r <= tran_mem[rd_addr];
    end
  end

  // Latch the item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r  <= in_code;
      label_r <= in_label;
      rbin_r  <= in_rbin;
      addr_r  <= rd_addr;
      oob_r   <= (rcol32 >= 32'(MAX_COLUMNS));
    end
  end

  // Advance sequence state and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      prev_gap_r <= 1'b0;
      member_r   <= 1'b0;
      members_r  <= '0;
      clr_cnt_r  <= '0;
    end else if (cmd.clr_init) begin
      pos_r      <= '0;
      prev_gap_r <= 1'b0;
      member_r   <= 1'b0;
      members_r  <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.do_acc) begin
        pos_r      <= pos_nxt;
        prev_gap_r <= gap;
        member_r   <= member_nxt;
        if (first_col && member_nxt) begin
          members_r <= sat_inc(members_r);
        end
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
    end
  end

  // Select the requested entry from the read rows
  always_comb begin
    entry = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (rbin_r == RBIN_W'(i)) begin
        entry = res_rd_r[i*CNT_W +: CNT_W];
      end
    end
    for (int j = 0; j < TRAN_BINS; j++) begin
      if (rbin_r == RBIN_W'(ALPHABET_SIZE + j)) begin
        entry = tran_rd_r[j*CNT_W +: CNT_W];
      end
    end
    if (oob_r) begin
      entry = '0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {OUT_PAD_W'(0), members_r, entry};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.func     = in_tuser;
  assign sts.clr_last = (clr_cnt_r == CW'(MAX_COLUMNS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  `ACPC_ASSERT_NOW(a_members_sat, 1'b1, members_r <= CNT_MAX,
    "member count above saturation")
  `ACPC_ASSERT_NOW(a_out_from_load, $rose(out_valid_r), $past(cmd.load_out),
    "result appeared without a load")
  `ACPC_ASSERT_NEXT(a_clear_init, cmd.clr_init,
    (clr_cnt_r == '0) && (members_r == '0), "clear did not restart counters")

endmodule

// File: hw/rtl/alignment_column_profile_counter_core.sv
// Accumulate item: row read, then saturating update and write-back.
// Read item: row read, then the output register is loaded, waiting while a result is still held there.
// Clear item: sweeps every column row of both memories, one column row per cycle.
// Rate is set by the single write port of the two count memories (read, then write).
// Reset (rst_n low, synchronous) runs the same clearing pass;
// configuration writes are taken throughout.
module alignment_column_profile_counter_core #(
  parameter int MAX_COLUMNS = acpc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [acpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // residue_code[4:0], cluster_label[16:5], read_column[26:17], read_bin[31:27]
  input  logic [acpc_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [acpc_pkg::FUNC_W-1:0]     in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // entry_count[12:0], member_count[25:13], zero[31:26]
  output logic [acpc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import acpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  acpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acpc_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: dv/acpc_profile_checker.sv
`timescale 1ns / 100ps
// Profile counter checker: watches the channels, predicts read replies and compares them.
module acpc_profile_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [acpc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [acpc_pkg::FUNC_W-1:0]     in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [acpc_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              replies_pending
);
  import acpc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] entry;
    logic [CNT_W-1:0] members;
  } read_reply_t;

  // Predicted profile state
  logic [CNT_W-1:0]    residue_tally [MAX_COLUMNS_DEF*ALPHABET_SIZE];
  logic [CNT_W-1:0]    transit_tally [MAX_COLUMNS_DEF*TRAN_BINS];
  logic [CCOUNT_W-1:0] cols_reg;
  logic [LABEL_W-1:0]  target_reg;
  int unsigned         col_pos;
  bit                  prev_gap;
  bit                  in_member;
  logic [CNT_W-1:0]    member_tally;
  read_reply_t         reply_q[$];

  function automatic logic [CNT_W-1:0] saturating_step(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

  // Zero all counts and restart at column 0
  function void clear_profile();
    for (int i = 0; i < MAX_COLUMNS_DEF * ALPHABET_SIZE; i++) residue_tally[i] = '0;
    for (int i = 0; i < MAX_COLUMNS_DEF * TRAN_BINS; i++) transit_tally[i] = '0;
    col_pos      = 0;
    prev_gap     = 1'b0;
    in_member    = 1'b0;
    member_tally = '0;
  endfunction

  // Count one residue of the running sequence
  function void count_residue(input logic [CODE_W-1:0] code, input logic [LABEL_W-1:0] label);
    int unsigned len;
    int unsigned col;
    int unsigned origin;
    bit          gap;
    len = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_reg;
    col = (col_pos >= len) ? len - 1 : col_pos;
    gap = (code >= ALPHABET_SIZE);
    if (col == 0) begin
      in_member = (label == target_reg);
      if (in_member) member_tally = saturating_step(member_tally);
    end
    if (in_member) begin
      origin = (col != 0 && prev_gap) ? 1 : 0;
      if (!gap) begin
        residue_tally[col*ALPHABET_SIZE + code] =
          saturating_step(residue_tally[col*ALPHABET_SIZE + code]);
      end
      transit_tally[col*TRAN_BINS + origin*2 + (gap ? 1 : 0)] =
        saturating_step(transit_tally[col*TRAN_BINS + origin*2 + (gap ? 1 : 0)]);
    end
    prev_gap = gap;
    col_pos  = (col + 1 >= len) ? 0 : col + 1;
  endfunction

  function logic [CNT_W-1:0] lookup_entry(input logic [RCOL_W-1:0] col,
                                          input logic [RBIN_W-1:0] bin);
    if (bin < ALPHABET_SIZE) return residue_tally[col*ALPHABET_SIZE + bin];
    if (bin < ALPHABET_SIZE + TRAN_BINS)
      return transit_tally[col*TRAN_BINS + (bin - ALPHABET_SIZE)];
    return '0;
  endfunction

  task report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Track config writes and items, check each result against the oldest reply
  always @(posedge clk) begin
    read_reply_t want;
    if (!rst_n) begin
      cols_reg   = COLUMN_COUNT_RST;
      target_reg = '0;
      clear_profile();
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMN_COUNT:   cols_reg   = cfg_wdata[CCOUNT_W-1:0];
          REG_TARGET_CLUSTER: target_reg = cfg_wdata[LABEL_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with no read pending, entry_count",
                          out_tdata[CNT_W-1:0], 0);
        end else begin
          want = reply_q.pop_front();
          if (out_tdata[CNT_W-1:0] !== want.entry)
            report_mismatch("entry_count", out_tdata[CNT_W-1:0], want.entry);
          if (out_tdata[2*CNT_W-1:CNT_W] !== want.members)
            report_mismatch("member_count", out_tdata[2*CNT_W-1:CNT_W], want.members);
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          FN_CLEAR: clear_profile();
          FN_ACCUM: count_residue(in_tdata[CODE_LSB +: CODE_W], in_tdata[LABEL_LSB +: LABEL_W]);
          FN_READ: begin
            want.entry   = lookup_entry(in_tdata[RCOL_LSB +: RCOL_W], in_tdata[RBIN_LSB +: RBIN_W]);
            want.members = member_tally;
            reply_q      = {reply_q, want};
          end
          default: ;
        endcase
      end
    end
    replies_pending = reply_q.size();
  end

endmodule

// File: dv/alignment_column_profile_counter_core_tb.sv
`timescale 1ns / 100ps
// Profile counter testbench top: clock, reset, stimulus, backpressure and verdict.
module alignment_column_profile_counter_core_tb;
  import acpc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = MAX_COLUMNS_DEF + 76;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 100;
  localparam int ONE_COL_ITEMS = 150;

  localparam logic [FUNC_W-1:0] FN_UNUSED     = 2'd3;
  localparam logic [RBIN_W-1:0] BIN_MATCH_RES = RBIN_W'(ALPHABET_SIZE);
  localparam logic [RBIN_W-1:0] BIN_MATCH_GAP = RBIN_W'(ALPHABET_SIZE + 1);
  localparam logic [RBIN_W-1:0] BIN_GAP_RES   = RBIN_W'(ALPHABET_SIZE + 2);
  localparam logic [RBIN_W-1:0] BIN_GAP_GAP   = RBIN_W'(ALPHABET_SIZE + 3);
  localparam logic [CODE_W-1:0] RES_LAST      = CODE_W'(ALPHABET_SIZE - 1);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fails;
  int pending;
  int cycle_count = 0;
  bit no_idle     = 1'b0;
  bit hold_req    = 1'b0;

  always #CLK_HALF clk = ~clk;

  alignment_column_profile_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  acpc_profile_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fails),
    .replies_pending (pending)
  );

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Drive result backpressure: one long hold on request, random stall bursts otherwise
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one item, with an optional idle burst first, and hold until accepted
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [CODE_W-1:0] code,
                           input logic [LABEL_W-1:0] label, input logic [RCOL_W-1:0] rcol,
                           input logic [RBIN_W-1:0] rbin);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {rbin, rcol, label, code};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic accum_item(input logic [CODE_W-1:0] code, input logic [LABEL_W-1:0] label);
    send_item(FN_ACCUM, code, label, RCOL_W'($urandom), RBIN_W'($urandom));
  endtask

  task automatic read_item(input logic [RCOL_W-1:0] rcol, input logic [RBIN_W-1:0] rbin);
    send_item(FN_READ, CODE_W'($urandom), LABEL_W'($urandom), rcol, rbin);
  endtask

  task automatic noise_item(input logic [FUNC_W-1:0] fn);
    send_item(fn, CODE_W'($urandom), LABEL_W'($urandom), RCOL_W'($urandom), RBIN_W'($urandom));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every reply, then let a clear pass run out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly member sequences with random residues, mixed with reads, clears and noise
  task automatic random_phase(input int n_items, input int len, input logic [LABEL_W-1:0] tgt);
    int                 sent;
    int                 r;
    logic [CODE_W-1:0]  code;
    logic [LABEL_W-1:0] lbl;
    logic [RCOL_W-1:0]  col;
    logic [RBIN_W-1:0]  bin;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r == 0) begin
        noise_item(FN_CLEAR);
        sent++;
      end else if (r < 3) begin
        noise_item(FN_UNUSED);
      end else if (r < 25) begin
        col = ($urandom_range(0, 7) == 0) ? RCOL_W'($urandom) : RCOL_W'($urandom_range(0, len - 1));
        bin = ($urandom_range(0, 9) == 0) ? RBIN_W'($urandom) : RBIN_W'($urandom_range(0, 23));
        read_item(col, bin);
        sent++;
      end else begin
        r = $urandom_range(0, 9);
        code = (r < 3) ? GAP_CODE :
               (r == 3) ? CODE_W'($urandom_range(ALPHABET_SIZE + 1, 31)) :
               CODE_W'($urandom_range(0, ALPHABET_SIZE - 1));
        lbl = ($urandom_range(0, 3) != 0) ? tgt : LABEL_W'($urandom);
        accum_item(code, lbl);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] cols_w;
    logic [CFG_DATA_W-1:0] tgt_w;
    logic [CCOUNT_W-1:0]   cols_v;
    int                    len;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short sequences of four columns, target cluster 5
    cfg_write(REG_TARGET_CLUSTER, 12'd5);
    cfg_write(REG_COLUMN_COUNT, 12'd4);
    read_item(10'd0, 5'd0);
    accum_item(5'd0, 12'd5);
    accum_item(GAP_CODE, 12'd0);
    accum_item(GAP_CODE, 12'hFFF);
    accum_item(RES_LAST, 12'd5);
    // non-member sequence with the top label
    accum_item(5'd3, 12'hFFF);
    accum_item(5'd3, 12'd5);
    accum_item(GAP_CODE, 12'd5);
    accum_item(5'd3, 12'd5);
    // codes above the gap code count as gaps
    accum_item(5'd31, 12'd5);
    accum_item(5'd7, 12'd0);
    accum_item(GAP_CODE + 5'd1, 12'd0);
    accum_item(GAP_CODE, 12'd0);
    read_item(10'd0, 5'd0);
    read_item(10'd0, BIN_MATCH_GAP);
    read_item(10'd1, BIN_MATCH_RES);
    read_item(10'd1, BIN_GAP_RES);
    read_item(10'd2, BIN_GAP_GAP);
    read_item(10'd3, RES_LAST);
    // out-of-range bins and a column past the sequence length
    read_item(10'd1, 5'd24);
    read_item(10'd1, 5'd31);
    read_item(10'd1023, 5'd0);
    noise_item(FN_UNUSED);
    noise_item(FN_CLEAR);
    read_item(10'd0, 5'd0);
    settle();

    // Random phases over a spread of lengths and targets
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       begin cols_w = 12'd1;    tgt_w = 12'd0;   end
        1:       begin cols_w = 12'd3;    tgt_w = 12'hFFF; end
        2:       begin cols_w = 12'd0;    tgt_w = 12'd17;  end
        3:       begin cols_w = 12'hFFF;  tgt_w = 12'd0;   end
        4:       begin cols_w = 12'h805;  tgt_w = 12'($urandom); end
        5:       begin cols_w = 12'd1024; tgt_w = 12'hFFF; end
        default: begin cols_w = 12'd8;    tgt_w = 12'd1;   end
      endcase
      if (phase % 2 == 0) begin
        cfg_write(REG_COLUMN_COUNT, cols_w);
        cfg_write(REG_TARGET_CLUSTER, tgt_w);
      end else begin
        cfg_write(REG_TARGET_CLUSTER, tgt_w);
        cfg_write(REG_COLUMN_COUNT, cols_w);
      end
      cols_v = cols_w[CCOUNT_W-1:0];
      len = (cols_v == 0) ? 1 : (cols_v > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_v;
      if (phase == 1) begin
        // hold the result side off while reads keep coming, so the input stalls
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (40) read_item(RCOL_W'($urandom_range(0, len - 1)), RBIN_W'($urandom_range(0, 23)));
        no_idle = 1'b0;
      end
      if (phase == 5) no_idle = 1'b1;
      random_phase(PHASE_ITEMS, len, tgt_w[LABEL_W-1:0]);
      no_idle = 1'b0;
      settle();
    end

    // One-column sequences, nearly all members with the same residue
    cfg_write(REG_COLUMN_COUNT, 12'd1);
    cfg_write(REG_TARGET_CLUSTER, 12'hFFF);
    for (int k = 0; k < ONE_COL_ITEMS; k++) begin
      accum_item(($urandom_range(0, 49) == 0) ? GAP_CODE : 5'd0,
                 ($urandom_range(0, 49) == 0) ? 12'($urandom) : 12'hFFF);
      if (k % 50 == 0) read_item(10'd0, ($urandom_range(0, 1) == 0) ? 5'd0 : BIN_MATCH_RES);
    end
    read_item(10'd0, 5'd0);
    read_item(10'd0, BIN_MATCH_RES);
    read_item(10'd0, BIN_MATCH_GAP);
    settle();

    // Tail: random setting, no idling on either side
    no_idle = 1'b1;
    cols_w  = 12'($urandom_range(1, 16));
    tgt_w   = 12'($urandom);
    cfg_write(REG_COLUMN_COUNT, cols_w);
    cfg_write(REG_TARGET_CLUSTER, tgt_w);
    random_phase(PHASE_ITEMS, int'(cols_w), tgt_w[LABEL_W-1:0]);
    settle();

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/acpc_pkg.sv
hw/rtl/acpc_ctrl.sv
hw/rtl/acpc_dp.sv
hw/rtl/alignment_column_profile_counter_core.sv
dv/acpc_profile_checker.sv
dv/alignment_column_profile_counter_core_tb.sv
